[rtl/skrw_pkg.sv]
// ----------------------------------------------------------------------------
// skrw_pkg: shared types and constants
// Widths, reset values, register indexes and the instant score table of the
// five-channel Kalman conditioner with reliability weighting.
// ----------------------------------------------------------------------------
package skrw_pkg;

   localparam int CHANNELS   = 5;
   localparam int RAW_W      = 24;
   localparam int RANGE_W    = 23;
   localparam int FRAC_W     = 16;
   localparam int EST_W      = 32;
   localparam int FC_W       = 6;
   localparam int TOTAL_W    = $clog2(CHANNELS * 32768 + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   localparam logic [FRAC_W-1:0] ONE_Q15     = 16'd32768;
   localparam logic [FRAC_W-1:0] GAIN_HIGH   = 16'd26214;
   localparam logic [FRAC_W-1:0] RECIP_FIVE  = 16'd52429;
   localparam logic [FC_W-1:0]   FAULT_LIMIT = 6'd5;
   localparam logic [FC_W-1:0]   FAULT_MAX   = 6'd63;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_AIR_TEMP      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_AIR_HUMIDITY  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_SOIL_HUMIDITY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LIGHT         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LIQUID_LEVEL  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASURE_NOISE       = 3'd6;

   localparam logic [FRAC_W-1:0] Q_RESET = 16'd328;
   localparam logic [FRAC_W-1:0] R_RESET = 16'd3277;

   localparam logic signed [EST_W-1:0] EST_RESET [CHANNELS] =
      '{32'sd6400, 32'sd15360, 32'sd12800, 32'sd128000, 32'sd20480};
   localparam logic [FRAC_W-1:0] WEIGHT_RESET [CHANNELS] =
      '{16'd6554, 16'd6554, 16'd9830, 16'd4915, 16'd4915};
   localparam logic [RANGE_W-1:0] RANGE_RESET [CHANNELS] =
      '{23'd10240, 23'd25600, 23'd25600, 23'd2560000, 23'd25600};

   // bit0 fault, bit1 high gain, bit2 unhealthy
   function automatic logic [FRAC_W-1:0] instant_score(input logic [2:0] sel);
      logic [FRAC_W-1:0] s;
      case (sel)
         3'd0:    s = 16'd32768;
         3'd1:    s = 16'd3277;
         3'd2:    s = 16'd22938;
         3'd3:    s = 16'd2294;
         3'd4:    s = 16'd9830;
         3'd5:    s = 16'd983;
         3'd6:    s = 16'd6881;
         default: s = 16'd688;
      endcase
      return s;
   endfunction

   typedef struct packed {
      logic start;
      logic total_go;
      logic ack;
   } lane_ctl_type;

   typedef struct packed {
      logic rel_ready;
      logic done;
   } lane_sts_type;

endpackage

[rtl/skrw_if.sv]
// ----------------------------------------------------------------------------
// skrw_req_if / skrw_rsp_if: request and response channels
// Valid/ready channels carrying the raw samples and the conditioned results.
// ----------------------------------------------------------------------------
interface skrw_req_if;
   logic valid;
   logic ready;
   logic signed [skrw_pkg::RAW_W-1:0] raw_air_temp;
   logic signed [skrw_pkg::RAW_W-1:0] raw_air_humidity;
   logic signed [skrw_pkg::RAW_W-1:0] raw_soil_humidity;
   logic signed [skrw_pkg::RAW_W-1:0] raw_light;
   logic signed [skrw_pkg::RAW_W-1:0] raw_liquid_level;

   modport source (output valid, raw_air_temp, raw_air_humidity, raw_soil_humidity,
                   raw_light, raw_liquid_level, input ready);
   modport sink   (input valid, raw_air_temp, raw_air_humidity, raw_soil_humidity,
                   raw_light, raw_liquid_level, output ready);
endinterface

interface skrw_rsp_if;
   logic valid;
   logic ready;
   logic [skrw_pkg::FRAC_W-1:0] norm_air_temp;
   logic [skrw_pkg::FRAC_W-1:0] norm_air_humidity;
   logic [skrw_pkg::FRAC_W-1:0] norm_soil_humidity;
   logic [skrw_pkg::FRAC_W-1:0] norm_light;
   logic [skrw_pkg::FRAC_W-1:0] norm_liquid_level;
   logic [skrw_pkg::FRAC_W-1:0] weight_air_temp;
   logic [skrw_pkg::FRAC_W-1:0] weight_air_humidity;
   logic [skrw_pkg::FRAC_W-1:0] weight_soil_humidity;
   logic [skrw_pkg::FRAC_W-1:0] weight_light;
   logic [skrw_pkg::FRAC_W-1:0] weight_liquid_level;
   logic [skrw_pkg::CHANNELS-1:0] healthy_mask;

   modport source (output valid, norm_air_temp, norm_air_humidity, norm_soil_humidity,
                   norm_light, norm_liquid_level, weight_air_temp, weight_air_humidity,
                   weight_soil_humidity, weight_light, weight_liquid_level,
                   healthy_mask, input ready);
   modport sink   (input valid, norm_air_temp, norm_air_humidity, norm_soil_humidity,
                   norm_light, norm_liquid_level, weight_air_temp, weight_air_humidity,
                   weight_soil_humidity, weight_light, weight_liquid_level,
                   healthy_mask, output ready);
endinterface

[rtl/sensor_kalman_reliability_weighting.sv]
// ----------------------------------------------------------------------------
// sensor_kalman_reliability_weighting: five-channel sensor conditioner
// Kalman filtering, normalization and reliability weighting of five sensors.
// ----------------------------------------------------------------------------
// one request in flight at a time: ready stays low from acceptance until the
//   response is registered, while the three 16-step serial divides (gain,
//   norm, weight) run in each channel lane
// a request is taken while the previous response still waits in its register
// reset: synchronous; filter state and control registers return to defaults
module sensor_kalman_reliability_weighting (
   input  logic                                clock,
   input  logic                                reset,
   skrw_req_if.sink                            req_ch,
   skrw_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [skrw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [skrw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [skrw_pkg::RANGE_W-1:0]   range_ff [skrw_pkg::CHANNELS];
   logic [skrw_pkg::FRAC_W-1:0]    q_ff;
   logic [skrw_pkg::FRAC_W-1:0]    r_ff;
   logic                           busy_ff;

   logic signed [skrw_pkg::RAW_W-1:0] raw_a [skrw_pkg::CHANNELS];
   skrw_pkg::lane_ctl_type         ctl;
   skrw_pkg::lane_sts_type         sts      [skrw_pkg::CHANNELS];
   logic [skrw_pkg::FRAC_W-1:0]    rel_a    [skrw_pkg::CHANNELS];
   logic [skrw_pkg::FRAC_W-1:0]    norm_a   [skrw_pkg::CHANNELS];
   logic [skrw_pkg::FRAC_W-1:0]    wq_a     [skrw_pkg::CHANNELS];
   logic [skrw_pkg::FRAC_W-1:0]    onorm_a  [skrw_pkg::CHANNELS];
   logic [skrw_pkg::FRAC_W-1:0]    oweight_a[skrw_pkg::CHANNELS];
   logic [skrw_pkg::CHANNELS-1:0]  healthy_a;
   logic [skrw_pkg::TOTAL_W-1:0]   total;
   logic                           total_go;
   logic                           ack;
   logic                           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < skrw_pkg::CHANNELS; i++) begin
            range_ff[i] <= skrw_pkg::RANGE_RESET[i];
         end
         q_ff <= skrw_pkg::Q_RESET;
         r_ff <= skrw_pkg::R_RESET;
      end else if (csr_we) begin
         unique case (csr_index) inside
            skrw_pkg::CSR_RANGE_AIR_TEMP, skrw_pkg::CSR_RANGE_AIR_HUMIDITY,
            skrw_pkg::CSR_RANGE_SOIL_HUMIDITY, skrw_pkg::CSR_RANGE_LIGHT,
            skrw_pkg::CSR_RANGE_LIQUID_LEVEL: begin
               range_ff[csr_index] <= csr_wdata;
            end
            skrw_pkg::CSR_PROCESS_NOISE: q_ff <= csr_wdata[skrw_pkg::FRAC_W-1:0];
            skrw_pkg::CSR_MEASURE_NOISE: r_ff <= csr_wdata[skrw_pkg::FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ch.ready = !busy_ff;
   assign accept       = req_ch.valid && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (ack) begin
         busy_ff <= 1'b0;
      end
   end

   assign raw_a[0] = req_ch.raw_air_temp;
   assign raw_a[1] = req_ch.raw_air_humidity;
   assign raw_a[2] = req_ch.raw_soil_humidity;
   assign raw_a[3] = req_ch.raw_light;
   assign raw_a[4] = req_ch.raw_liquid_level;

   assign ctl.start    = accept;
   assign ctl.total_go = total_go;
   assign ctl.ack      = ack;

   for (genvar g = 0; g < skrw_pkg::CHANNELS; g++) begin : g_lane
      skrw_lane #(.LANE(g)) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .raw       (raw_a[g]),
         .range_val (range_ff[g]),
         .q_val     (q_ff),
         .r_val     (r_ff),
         .total     (total),
         .sts       (sts[g]),
         .rel       (rel_a[g]),
         .norm      (norm_a[g]),
         .weight    (wq_a[g]),
         .healthy   (healthy_a[g])
      );
   end

   skrw_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .sts        (sts),
      .rel        (rel_a),
      .norm       (norm_a),
      .wq         (wq_a),
      .healthy    (healthy_a),
      .total      (total),
      .total_go   (total_go),
      .ack        (ack),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .out_norm   (onorm_a),
      .out_weight (oweight_a),
      .out_mask   (rsp_ch.healthy_mask)
   );

   assign rsp_ch.norm_air_temp        = onorm_a[0];
   assign rsp_ch.norm_air_humidity    = onorm_a[1];
   assign rsp_ch.norm_soil_humidity   = onorm_a[2];
   assign rsp_ch.norm_light           = onorm_a[3];
   assign rsp_ch.norm_liquid_level    = onorm_a[4];
   assign rsp_ch.weight_air_temp      = oweight_a[0];
   assign rsp_ch.weight_air_humidity  = oweight_a[1];
   assign rsp_ch.weight_soil_humidity = oweight_a[2];
   assign rsp_ch.weight_light         = oweight_a[3];
   assign rsp_ch.weight_liquid_level  = oweight_a[4];

endmodule

[rtl/skrw_lane.sv]
// ----------------------------------------------------------------------------
// skrw_lane: one sensor channel
// Scalar Kalman update, normalization, fault counting and reliability score,
// with one serial restoring divider shared by gain, norm and weight.
// ----------------------------------------------------------------------------
module skrw_lane #(
   parameter int LANE = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  skrw_pkg::lane_ctl_type                 ctl,
   input  logic signed [skrw_pkg::RAW_W-1:0]      raw,
   input  logic [skrw_pkg::RANGE_W-1:0]           range_val,
   input  logic [skrw_pkg::FRAC_W-1:0]            q_val,
   input  logic [skrw_pkg::FRAC_W-1:0]            r_val,
   input  logic [skrw_pkg::TOTAL_W-1:0]           total,
   output skrw_pkg::lane_sts_type                 sts,
   output logic [skrw_pkg::FRAC_W-1:0]            rel,
   output logic [skrw_pkg::FRAC_W-1:0]            norm,
   output logic [skrw_pkg::FRAC_W-1:0]            weight,
   output logic                                   healthy
);

   typedef enum logic [2:0] {
      L_IDLE, L_KDIV, L_UPD, L_REL, L_NDIV, L_WAIT, L_WDIV, L_DONE
   } lstate_type;

   localparam int RW = skrw_pkg::RANGE_W;

   lstate_type                           state_ff;
   logic signed [skrw_pkg::EST_W-1:0]    est_ff;
   logic [skrw_pkg::FRAC_W-1:0]          p_ff;
   logic [skrw_pkg::FC_W-1:0]            fc_ff;
   logic [skrw_pkg::FRAC_W-1:0]          rel_ff;
   logic signed [skrw_pkg::RAW_W-1:0]    raw_ff;
   logic [16:0]                          pp_ff;
   logic [2:0]                           sel_ff;
   logic                                 den_zero_ff;
   logic                                 norm_zero_ff;
   logic                                 norm_full_ff;
   logic [skrw_pkg::FRAC_W-1:0]          norm_ff;
   logic [skrw_pkg::FRAC_W-1:0]          weight_ff;
   logic [RW-1:0]                        rem_ff;
   logic [15:0]                          lo_ff;
   logic [15:0]                          quo_ff;
   logic [RW-1:0]                        div_ff;
   logic [3:0]                           cnt_ff;

   logic [16:0]                          pp_in;
   logic [17:0]                          den_in;
   logic [RW:0]                          trial;
   logic [RW+1:0]                        sub;
   logic                                 ge;
   logic [RW-1:0]                        rem_in;
   logic [15:0]                          quo_in;
   logic [15:0]                          k_c;
   logic signed [32:0]                   diff_c;
   logic signed [49:0]                   prod_c;
   logic signed [skrw_pkg::EST_W-1:0]    est_in;
   logic [33:0]                          pmul_c;
   logic [skrw_pkg::FRAC_W-1:0]          p_in;
   logic                                 fault_c;
   logic [24:0]                          raw2_c;
   logic [24:0]                          range3_c;
   logic [skrw_pkg::FC_W-1:0]            fc_in;
   logic [17:0]                          relsum_c;
   logic [33:0]                          rmul_c;

   always_comb begin
      pp_in  = {1'b0, p_ff} + {1'b0, q_val};
      den_in = {1'b0, pp_in} + {2'b0, r_val};

      // restoring divide step
      trial  = {rem_ff, lo_ff[15]};
      sub    = {1'b0, trial} - {2'b0, div_ff};
      ge     = !sub[RW+1];
      rem_in = ge ? sub[RW-1:0] : trial[RW-1:0];
      quo_in = {quo_ff[14:0], ge};

      k_c    = den_zero_ff ? '0 : quo_ff;
      diff_c = 33'(raw_ff) - 33'(est_ff);
      prod_c = $signed({1'b0, k_c}) * diff_c;
      est_in = est_ff + prod_c[46:15];
      pmul_c = ({1'b0, skrw_pkg::ONE_Q15} - {1'b0, k_c}) * pp_ff;
      p_in   = (|pmul_c[33:31]) ? 16'hFFFF : pmul_c[30:15];

      raw2_c   = {1'b0, raw_ff[22:0], 1'b0};
      range3_c = {2'b0, range_val} + {1'b0, range_val, 1'b0};
      fault_c  = raw_ff[23] || (raw_ff == '0) || (raw2_c > range3_c);
      if (fault_c) begin
         fc_in = (fc_ff == skrw_pkg::FAULT_MAX) ? fc_ff : fc_ff + 1'b1;
      end else begin
         fc_in = (fc_ff == '0) ? fc_ff : fc_ff - 1'b1;
      end

      relsum_c = {rel_ff, 2'b0} + {2'b0, skrw_pkg::instant_score(sel_ff)} + 18'd2;
      // divide by five through the reciprocal, exact below 2^18
      rmul_c   = relsum_c * skrw_pkg::RECIP_FIVE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         est_ff   <= skrw_pkg::EST_RESET[LANE];
         p_ff     <= skrw_pkg::ONE_Q15;
         fc_ff    <= '0;
         rel_ff   <= skrw_pkg::ONE_Q15;
         sel_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         if (state_ff == L_KDIV || state_ff == L_NDIV || state_ff == L_WDIV) begin
            rem_ff <= rem_in;
            lo_ff  <= {lo_ff[14:0], 1'b0};
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 1'b1;
         end
         unique case (state_ff)
            L_IDLE: begin
               if (ctl.start) begin
                  raw_ff      <= raw;
                  pp_ff       <= pp_in;
                  den_zero_ff <= (den_in == '0);
                  rem_ff      <= RW'(pp_in[16:1]);
                  lo_ff       <= {pp_in[0], 15'b0};
                  div_ff      <= RW'(den_in);
                  cnt_ff      <= '0;
                  state_ff    <= L_KDIV;
               end
            end
            L_KDIV: begin
               if (cnt_ff == 4'd15) state_ff <= L_UPD;
            end
            L_UPD: begin
               est_ff   <= est_in;
               p_ff     <= p_in;
               fc_ff    <= fc_in;
               sel_ff   <= {fc_in > skrw_pkg::FAULT_LIMIT, k_c > skrw_pkg::GAIN_HIGH,
                            fault_c};
               state_ff <= L_REL;
            end
            L_REL: begin
               rel_ff       <= rmul_c[33:18];
               norm_zero_ff <= (range_val == '0) || est_ff[31] || (est_ff == '0);
               norm_full_ff <= (est_ff >= $signed({9'b0, range_val}));
               rem_ff       <= {1'b0, est_ff[22:1]};
               lo_ff        <= {est_ff[0], 15'b0};
               div_ff       <= range_val;
               cnt_ff       <= '0;
               state_ff     <= L_NDIV;
            end
            L_NDIV: begin
               if (cnt_ff == 4'd15) begin
                  norm_ff  <= norm_zero_ff ? '0 :
                              norm_full_ff ? skrw_pkg::ONE_Q15 : quo_in;
                  state_ff <= L_WAIT;
               end
            end
            L_WAIT: begin
               if (ctl.total_go) begin
                  rem_ff   <= RW'(rel_ff[15:1]);
                  lo_ff    <= {rel_ff[0], 15'b0};
                  div_ff   <= RW'(total);
                  cnt_ff   <= '0;
                  state_ff <= L_WDIV;
               end
            end
            L_WDIV: begin
               if (cnt_ff == 4'd15) begin
                  weight_ff <= quo_in;
                  state_ff  <= L_DONE;
               end
            end
            L_DONE: begin
               if (ctl.ack) state_ff <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign sts.rel_ready = (state_ff == L_WAIT);
   assign sts.done      = (state_ff == L_DONE);
   assign rel           = rel_ff;
   assign norm          = norm_ff;
   assign weight        = weight_ff;
   assign healthy       = !sel_ff[2];

endmodule

[rtl/skrw_merge.sv]
// ----------------------------------------------------------------------------
// skrw_merge: lane merge and response register
// Sums the lane reliabilities, releases the weight divide, keeps the channel
// weights and holds the response until it is taken.
// ----------------------------------------------------------------------------
module skrw_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  skrw_pkg::lane_sts_type              sts     [skrw_pkg::CHANNELS],
   input  logic [skrw_pkg::FRAC_W-1:0]         rel     [skrw_pkg::CHANNELS],
   input  logic [skrw_pkg::FRAC_W-1:0]         norm    [skrw_pkg::CHANNELS],
   input  logic [skrw_pkg::FRAC_W-1:0]         wq      [skrw_pkg::CHANNELS],
   input  logic [skrw_pkg::CHANNELS-1:0]       healthy,
   output logic [skrw_pkg::TOTAL_W-1:0]        total,
   output logic                                total_go,
   output logic                                ack,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [skrw_pkg::FRAC_W-1:0]         out_norm   [skrw_pkg::CHANNELS],
   output logic [skrw_pkg::FRAC_W-1:0]         out_weight [skrw_pkg::CHANNELS],
   output logic [skrw_pkg::CHANNELS-1:0]       out_mask
);

   typedef enum logic [1:0] {M_SUM, M_GO, M_WAIT} mstate_type;

   mstate_type                     state_ff;
   logic [skrw_pkg::TOTAL_W-1:0]   total_ff;
   logic                           valid_ff;
   logic [skrw_pkg::FRAC_W-1:0]    norm_ff   [skrw_pkg::CHANNELS];
   logic [skrw_pkg::FRAC_W-1:0]    weight_ff [skrw_pkg::CHANNELS];
   logic [skrw_pkg::CHANNELS-1:0]  mask_ff;

   logic [skrw_pkg::TOTAL_W-1:0]   sum_c;
   logic                           all_rel;
   logic                           all_done;

   always_comb begin
      sum_c    = '0;
      all_rel  = 1'b1;
      all_done = 1'b1;
      for (int i = 0; i < skrw_pkg::CHANNELS; i++) begin
         sum_c    = sum_c + skrw_pkg::TOTAL_W'(rel[i]);
         all_rel  = all_rel & sts[i].rel_ready;
         all_done = all_done & sts[i].done;
      end
   end

   assign ack      = (state_ff == M_WAIT) && all_done && (!valid_ff || rsp_ready);
   assign total_go = (state_ff == M_GO);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_SUM;
         valid_ff <= 1'b0;
         for (int i = 0; i < skrw_pkg::CHANNELS; i++) begin
            weight_ff[i] <= skrw_pkg::WEIGHT_RESET[i];
         end
      end else begin
         if (ack) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
         unique case (state_ff)
            M_SUM: begin
               if (all_rel) begin
                  total_ff <= sum_c;
                  state_ff <= M_GO;
               end
            end
            M_GO: state_ff <= M_WAIT;
            M_WAIT: begin
               if (ack) begin
                  mask_ff  <= healthy;
                  for (int i = 0; i < skrw_pkg::CHANNELS; i++) begin
                     norm_ff[i] <= norm[i];
                     // zero total keeps the previous weights
                     if (total_ff != '0) weight_ff[i] <= wq[i];
                  end
                  state_ff <= M_SUM;
               end
            end
            default: state_ff <= M_SUM;
         endcase
      end
   end

   assign total      = total_ff;
   assign rsp_valid  = valid_ff;
   assign out_norm   = norm_ff;
   assign out_weight = weight_ff;
   assign out_mask   = mask_ff;

endmodule

[rtl/skrw_checker.sv]
// ----------------------------------------------------------------------------
// skrw_checker: port-level checks
// Watches the channel ports of the conditioner over time.
// ----------------------------------------------------------------------------
module skrw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] w0,
   input logic [15:0] w1,
   input logic [15:0] w2,
   input logic [15:0] w3,
   input logic [15:0] w4
);

   logic [18:0] wsum;
   assign wsum = {3'b0, w0} + {3'b0, w1} + {3'b0, w2} + {3'b0, w3} + {3'b0, w4};

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // only one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before taken");

   // floored shares never exceed one
   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> wsum <= 19'd32768)
      else $error("weights sum above one");

endmodule

bind sensor_kalman_reliability_weighting skrw_checker u_skrw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .w0        (rsp_ch.weight_air_temp),
   .w1        (rsp_ch.weight_air_humidity),
   .w2        (rsp_ch.weight_soil_humidity),
   .w3        (rsp_ch.weight_light),
   .w4        (rsp_ch.weight_liquid_level)
);

[sim/skrw_tb_if.sv]
// ----------------------------------------------------------------------------
// skrw test channels
// The block's own channel interfaces live with the RTL; only the scoreboard's result type is added here.
// ----------------------------------------------------------------------------
// note: the interfaces skrw_req_if and skrw_rsp_if come from rtl/skrw_if.sv
package skrw_tb_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] norm [5];
      logic [15:0] weight [5];
      logic [4:0]  healthy;
   } conditioned_type;
endpackage

[sim/sensor_kalman_reliability_weighting_checker.sv]
// ----------------------------------------------------------------------------
// sensor_kalman_reliability_weighting_checker: response scoreboard
// Mirrors filter, fault and reliability state per channel, predicts each
// response from the accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module sensor_kalman_reliability_weighting_checker (
   input  logic                               clock,
   input  logic                               reset,
   skrw_req_if                                req_ch,
   skrw_rsp_if                                rsp_ch,
   input  logic                               csr_we,
   input  logic [skrw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [skrw_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                 failures,
   output int                                 pending,
   output int                                 responses
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [22:0] range_q [5];
   logic [15:0] q_noise, r_noise;
   longint      est_q [5];
   longint      cov_q [5];
   int          faults_q [5];
   longint      rel_q [5];
   longint      weight_q [5];
   skrw_tb_pkg::conditioned_type expected_q [$];

   function automatic longint floor_shift15(longint x);
      if (x >= 0) return x >>> 15;
      return -((-x + 32767) >>> 15);
   endfunction

   function automatic longint score_of(logic [2:0] sel);
      case (sel)
         3'd0: return 32768;
         3'd1: return 3277;
         3'd2: return 22938;
         3'd3: return 2294;
         3'd4: return 9830;
         3'd5: return 983;
         3'd6: return 6881;
         default: return 688;
      endcase
   endfunction

   function automatic skrw_tb_pkg::conditioned_type condition(logic signed [23:0] raw [5]);
      skrw_tb_pkg::conditioned_type r;
      longint pp, den, k, p, e, rw, rg, total;
      logic [2:0] sel;
      total = 0;
      r.healthy = '0;
      for (int i = 0; i < 5; i++) begin
         rw = raw[i];
         rg = range_q[i];
         pp = cov_q[i] + q_noise;
         den = pp + r_noise;
         k = (den != 0) ? (pp * 32768) / den : 0;
         e = est_q[i] + floor_shift15(k * (rw - est_q[i]));
         e = longint'(int'(e));
         est_q[i] = e;
         p = ((32768 - k) * pp) >>> 15;
         cov_q[i] = (p > 65535) ? 65535 : p;
         if (rg == 0 || e <= 0) r.norm[i] = 0;
         else if (e >= rg) r.norm[i] = 16'd32768;
         else r.norm[i] = 16'((e * 32768) / rg);
         sel = '0;
         if (rw <= 0 || rw * 2 > rg * 3) begin
            sel[0] = 1'b1;
            if (faults_q[i] < 63) faults_q[i]++;
         end else if (faults_q[i] > 0) begin
            faults_q[i]--;
         end
         if (k > 26214) sel[1] = 1'b1;
         if (faults_q[i] > 5) sel[2] = 1'b1;
         else r.healthy[i] = 1'b1;
         rel_q[i] = (4 * rel_q[i] + score_of(sel) + 2) / 5;
         total += rel_q[i];
      end
      for (int i = 0; i < 5; i++) begin
         if (total != 0) weight_q[i] = (rel_q[i] * 32768) / total;
         r.weight[i] = 16'(weight_q[i]);
      end
      return r;
   endfunction

   task automatic compare(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      logic signed [23:0] raw [5];
      skrw_tb_pkg::conditioned_type want;
      logic [15:0] got_norm [5];
      logic [15:0] got_weight [5];
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            range_q[i] = skrw_pkg::RANGE_RESET[i];
            est_q[i] = skrw_pkg::EST_RESET[i];
            cov_q[i] = 32768;
            faults_q[i] = 0;
            rel_q[i] = 32768;
            weight_q[i] = skrw_pkg::WEIGHT_RESET[i];
         end
         q_noise = skrw_pkg::Q_RESET;
         r_noise = skrw_pkg::R_RESET;
         expected_q.delete();
         failures = 0;
         responses = 0;
      end else begin
         if (csr_we) begin
            if (csr_index <= skrw_pkg::CSR_RANGE_LIQUID_LEVEL) begin
               range_q[csr_index] = csr_wdata;
            end else if (csr_index == skrw_pkg::CSR_PROCESS_NOISE) begin
               q_noise = 16'(csr_wdata);
            end else if (csr_index == skrw_pkg::CSR_MEASURE_NOISE) begin
               r_noise = 16'(csr_wdata);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            responses++;
            got_norm = '{rsp_ch.norm_air_temp, rsp_ch.norm_air_humidity,
                         rsp_ch.norm_soil_humidity, rsp_ch.norm_light,
                         rsp_ch.norm_liquid_level};
            got_weight = '{rsp_ch.weight_air_temp, rsp_ch.weight_air_humidity,
                           rsp_ch.weight_soil_humidity, rsp_ch.weight_light,
                           rsp_ch.weight_liquid_level};
            if (expected_q.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               want = expected_q.pop_front();
               for (int i = 0; i < 5; i++) begin
                  compare($sformatf("norm[%0d]", i), want.norm[i], got_norm[i]);
                  compare($sformatf("weight[%0d]", i), want.weight[i], got_weight[i]);
               end
               compare("healthy_mask", 16'(want.healthy), 16'(rsp_ch.healthy_mask));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            raw = '{req_ch.raw_air_temp, req_ch.raw_air_humidity, req_ch.raw_soil_humidity,
                    req_ch.raw_light, req_ch.raw_liquid_level};
            expected_q.push_back(condition(raw));
         end
      end
      pending = expected_q.size();
   end
endmodule

[sim/sensor_kalman_reliability_weighting_test.sv]
// ----------------------------------------------------------------------------
// sensor_kalman_reliability_weighting_test: top-level testbench
// Drives directed and random sample requests through several register
// settings and idle/stall phases; the checker scores every response.
// ----------------------------------------------------------------------------
module sensor_kalman_reliability_weighting_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_W = skrw_pkg::CSR_IDX_W;
   localparam int DATA_W = skrw_pkg::CSR_DATA_W;
   localparam int LATENCY = 54;
   localparam longint CYCLE_LIMIT = 1600 * 8 * 700 + 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_wdata = '0;
   int failures, pending, responses;
   int send_idle = 0, rsp_stall = 0;
   int requests = 0;
   longint cycles = 0;

   skrw_req_if req_ch ();
   skrw_rsp_if rsp_ch ();

   sensor_kalman_reliability_weighting DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   sensor_kalman_reliability_weighting_checker checker_i (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .pending(pending), .responses(responses));

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.raw_air_temp = '0;
      req_ch.raw_air_humidity = '0;
      req_ch.raw_soil_humidity = '0;
      req_ch.raw_light = '0;
      req_ch.raw_liquid_level = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[sensor_kalman_reliability_weighting] ERROR");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ch.ready <= !reset && ($urandom_range(99) >= rsp_stall);

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // valid stays high after the handshake and drops only on an idle cycle or in drain
   task automatic send(logic signed [23:0] s [5]);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.raw_air_temp <= s[0];
      req_ch.raw_air_humidity <= s[1];
      req_ch.raw_soil_humidity <= s[2];
      req_ch.raw_light <= s[3];
      req_ch.raw_liquid_level <= s[4];
      do @(posedge clock); while (!req_ch.ready);
      requests++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic signed [23:0] pick_sample(int rng);
      case ($urandom_range(9))
         0: return 24'sh800000;
         1: return 24'sh7fffff;
         2: return 24'($urandom);
         3: return -24'($urandom_range(1000));
         4: return 0;
         default: return 24'($urandom_range(rng * 2 + 2) + ($urandom_range(3) == 0 ? rng : 0));
      endcase
   endfunction

   task automatic random_items(int n, int rng);
      logic signed [23:0] s [5];
      for (int j = 0; j < n; j++) begin
         // mostly in-range samples, mixed at random with extreme and faulty ones
         for (int i = 0; i < 5; i++)
            s[i] = ($urandom_range(3) != 0) ? 24'($urandom_range(rng + 1)) : pick_sample(rng);
         send(s);
      end
   endtask

   initial begin
      logic signed [23:0] s [5];
      int q_set [5] = '{0, 32768, 328, 65535, 1000};
      int r_set [5] = '{1, 32768, 3277, 0, 200};
      int rng_set [5] = '{25600, 8388607, 0, 1, 300};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, fault, high gain and unhealthy paths
      s = '{24'sh7fffff, 24'sh800000, 24'sd0, 24'sd1, -24'sd1};
      send(s);
      s = '{24'sd10240, 24'sd38400, 24'sd38401, 24'sd3840000, 24'sd12800};
      send(s);
      for (int j = 0; j < 8; j++) begin
         s = '{24'sd0, -24'sd5, 24'sh800000, 24'sd0, 24'sh7fffff};
         send(s);
      end
      for (int j = 0; j < 8; j++) begin
         s = '{24'sd5000, 24'sd12800, 24'sd12800, 24'sd1280000, 24'sd12800};
         send(s);
      end
      drain();
      write_reg(skrw_pkg::CSR_RANGE_AIR_TEMP, '0);
      write_reg(skrw_pkg::CSR_PROCESS_NOISE, '0);
      write_reg(skrw_pkg::CSR_MEASURE_NOISE, 23'd0);
      s = '{24'sd100, 24'sd100, 24'sd100, 24'sd100, 24'sd100};
      send(s);
      send(s);
      drain();

      // random phases through register settings and idling mixes
      for (int ph = 0; ph < 20; ph++) begin
         int rng;
         rng = rng_set[ph % 5];
         for (int i = 0; i < 5; i++)
            write_reg(IDX_W'(i), (ph % 5 == 1) ? 23'($urandom) : 23'(rng));
         write_reg(skrw_pkg::CSR_PROCESS_NOISE, 23'(q_set[ph % 5]));
         write_reg(skrw_pkg::CSR_MEASURE_NOISE, 23'(r_set[(ph + ph / 5) % 5]));
         // index past the last register is ignored
         write_reg(skrw_pkg::CSR_MEASURE_NOISE + 3'd1, 23'($urandom));
         case (ph % 4)
            0: begin send_idle = 0;  rsp_stall = 0;  end
            1: begin send_idle = 84; rsp_stall = 0;  end
            2: begin send_idle = 0;  rsp_stall = 84; end
            default: begin send_idle = 26; rsp_stall = 26; end
         endcase
         random_items(76, (rng == 0) ? 1000 : rng);
         drain();
      end

      $display("covered %0d requests and %0d responses across 20 register/idle phases",
               requests, responses);
      if (failures == 0) begin
         $display("[sensor_kalman_reliability_weighting] OK");
      end else begin
         $display("[sensor_kalman_reliability_weighting] ERROR");
      end
      $finish;
   end
endmodule
